FILE: hw/rtl/tgad_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TGA true-colour decoder package
// Shared types, result codes and queue sizing for the decoder blocks.
// ---------------------------------------------------------------------------
package tgad_pkg;

  // Result status codes.
  localparam logic [1:0] StatusPixel    = 2'd0;
  localparam logic [1:0] StatusBadHeader = 2'd1;
  localparam logic [1:0] StatusShort    = 2'd2;

  // Header layout.
  localparam logic [4:0] HdrLastPos  = 5'd17;
  localparam logic [7:0] TypeTrueCol = 8'd2;
  localparam logic [7:0] Depth24     = 8'd24;
  localparam logic [7:0] Depth32     = 8'd32;
  localparam logic [7:0] DescMask    = 8'hC0;
  localparam logic [7:0] OpaqueAlpha = 8'd255;

  // Default depth of the queue between the parser and the pixel stage.
  localparam int unsigned QueueDepthDefault = 4;

  // Operation handed from the parser to the pixel stage.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_ERROR = 2'd2
  } op_e;

  // One queue entry.
  typedef struct packed {
    op_e         op;
    logic [1:0]  status;
    logic [1:0]  slot;
    logic [7:0]  data;
    logic        deep;
    logic        done;
    logic [15:0] width;
    logic [15:0] height;
  } entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tga_truecolor_stream_decoder_unit.sv
`default_nettype none
// A completed result passes through the operation queue, then the output register.
// Throughput: one byte per cycle, set by the parser taking one beat a cycle
// while the queue has room; the queue absorbs result-side stalls until it
// holds QUEUE_DEPTH operations.
// Reset clears the parser state, the queue pointers and the result valid flag.
// ---------------------------------------------------------------------------
// TGA true-colour stream decoder
// Byte-stream decoder for uncompressed 24- and 32-bit TGA images.
// ---------------------------------------------------------------------------
module tga_truecolor_stream_decoder_unit
  import tgad_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic             done_res_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   not_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  assign in_ready_o = not_full;
  assign accept     = in_valid_i && not_full;

  // Header and pixel byte parser.
  tgad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // Operation queue.
  tgad_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .not_full_o   (not_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Pixel assembly and result register.
  tgad_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .done_res_o     (done_res_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tgad_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TGA decoder parser
// Walks the header, ID field and pixels; each pixel byte or fault becomes an
// operation for the pixel stage: hold a component, emit a pixel or an error.
// ---------------------------------------------------------------------------
module tgad_front
  import tgad_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic   end_of_file_i,
  output logic        push_o,
  output entry_t      entry_o
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  id_len_q, id_len_d;
  logic        cmap_ok_q, cmap_ok_d;
  logic        type_ok_q, type_ok_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        depth_ok_q, depth_ok_d;
  logic        deep_q, deep_d;
  logic [7:0]  skip_q, skip_d;
  logic [31:0] pix_rem_q, pix_rem_d;
  logic [1:0]  bip_q, bip_d;

  logic        hdr_valid;
  logic [1:0]  last_slot;

  assign last_slot = deep_q ? 2'd3 : 2'd2;
  assign hdr_valid = type_ok_q && cmap_ok_q && depth_ok_q && (width_q != '0)
                     && (height_q != '0) && ((data_byte_i & DescMask) == '0);

  // Next-state and operation decode for one accepted beat.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    id_len_d   = id_len_q;
    cmap_ok_d  = cmap_ok_q;
    type_ok_d  = type_ok_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_ok_d = depth_ok_q;
    deep_d     = deep_q;
    skip_d     = skip_q;
    pix_rem_d  = pix_rem_q;
    bip_d      = bip_q;
    push_o     = 1'b0;
    entry_o    = '{op: OP_ERROR, status: StatusShort, slot: bip_q, data: data_byte_i,
                   deep: deep_q, done: 1'b1, width: '0, height: '0};
    if (accept_i) begin
      case (phase_q)
        PH_HEADER: begin
          case (pos_q)
            5'd0:  id_len_d = data_byte_i;
            5'd1:  cmap_ok_d = (data_byte_i == '0);
            5'd2:  type_ok_d = (data_byte_i == TypeTrueCol);
            5'd12: width_d[7:0] = data_byte_i;
            5'd13: width_d[15:8] = data_byte_i;
            5'd14: height_d[7:0] = data_byte_i;
            5'd15: height_d[15:8] = data_byte_i;
            5'd16: begin
              depth_ok_d = (data_byte_i == Depth24) || (data_byte_i == Depth32);
              deep_d     = (data_byte_i == Depth32);
            end
            default: ;
          endcase
          if (pos_q != HdrLastPos) begin
            pos_d = pos_q + 5'd1;
            if (end_of_file_i) begin
              pos_d  = '0;
              bip_d  = '0;
              push_o = 1'b1;
            end
          end else begin
            pos_d = '0;
            bip_d = '0;
            if (!hdr_valid) begin
              push_o         = 1'b1;
              entry_o.status = StatusBadHeader;
              phase_d        = end_of_file_i ? PH_HEADER : PH_DRAIN;
            end else if (end_of_file_i) begin
              push_o = 1'b1;
            end else begin
              pix_rem_d = 32'(width_q) * 32'(height_q);
              skip_d    = id_len_q;
              phase_d   = (id_len_q != '0) ? PH_SKIP : PH_PIXELS;
            end
          end
        end
        PH_SKIP: begin
          if (end_of_file_i) begin
            push_o  = 1'b1;
            phase_d = PH_HEADER;
            pos_d   = '0;
            bip_d   = '0;
          end else begin
            skip_d = skip_q - 8'd1;
            if (skip_q == 8'd1) begin
              phase_d = PH_PIXELS;
              bip_d   = '0;
            end
          end
        end
        PH_PIXELS: begin
          push_o = 1'b1;
          if (bip_q != last_slot) begin
            bip_d      = bip_q + 2'd1;
            entry_o.op = OP_HOLD;
            if (end_of_file_i) begin
              entry_o.op = OP_ERROR;
              phase_d    = PH_HEADER;
              pos_d      = '0;
              bip_d      = '0;
            end
          end else begin
            bip_d     = '0;
            pix_rem_d = pix_rem_q - 32'd1;
            if (pix_rem_q == 32'd1) begin
              entry_o.op     = OP_PIXEL;
              entry_o.status = StatusPixel;
              entry_o.width  = width_q;
              entry_o.height = height_q;
              phase_d        = end_of_file_i ? PH_HEADER : PH_DRAIN;
              pos_d          = '0;
            end else if (end_of_file_i) begin
              phase_d = PH_HEADER;
              pos_d   = '0;
            end else begin
              entry_o.op     = OP_PIXEL;
              entry_o.status = StatusPixel;
              entry_o.done   = 1'b0;
            end
          end
        end
        PH_DRAIN: begin
          if (end_of_file_i) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      id_len_q   <= '0;
      cmap_ok_q  <= 1'b1;
      type_ok_q  <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      depth_ok_q <= 1'b0;
      deep_q     <= 1'b0;
      skip_q     <= '0;
      pix_rem_q  <= '0;
      bip_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      id_len_q   <= id_len_d;
      cmap_ok_q  <= cmap_ok_d;
      type_ok_q  <= type_ok_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_ok_q <= depth_ok_d;
      deep_q     <= deep_d;
      skip_q     <= skip_d;
      pix_rem_q  <= pix_rem_d;
      bip_q      <= bip_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tgad_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TGA decoder operation queue
// Small first-in first-out buffer between the parser and the pixel stage.
// ---------------------------------------------------------------------------
module tgad_queue
  import tgad_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    push_entry_i,
  output logic      not_full_o,
  output logic      head_valid_o,
  output entry_t    head_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign not_full_o   = (count_q != FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && not_full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tgad_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TGA decoder pixel stage
// Collects held colour components and builds RGBA or error results in an
// output register that parts the queue from the result channel.
// ---------------------------------------------------------------------------
module tgad_back
  import tgad_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        done_res_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);

  logic [23:0] held_q;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        done_q;
  logic [15:0] width_q, height_q;
  logic        load_out;
  logic        is_hold;

  assign is_hold  = (head_i.op == OP_HOLD);
  assign pop_o    = head_valid_i && (is_hold || !out_valid_q || out_ready_i);
  assign load_out = pop_o && !is_hold;

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Component store and result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      case (head_i.op)
        OP_HOLD: begin
          held_q[8*head_i.slot +: 8] <= head_i.data;
        end
        OP_PIXEL: begin
          status_q <= StatusPixel;
          red_q    <= head_i.deep ? held_q[23:16] : head_i.data;
          green_q  <= held_q[15:8];
          blue_q   <= held_q[7:0];
          alpha_q  <= head_i.deep ? head_i.data : OpaqueAlpha;
          done_q   <= head_i.done;
          width_q  <= head_i.width;
          height_q <= head_i.height;
        end
        default: begin
          status_q <= head_i.status;
          red_q    <= '0;
          green_q  <= '0;
          blue_q   <= '0;
          alpha_q  <= '0;
          done_q   <= 1'b1;
          width_q  <= '0;
          height_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign done_res_o     = done_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// TGA true-colour stream decoder testbench
// Feeds directed and random TGA byte streams through the decoder. Both
// channels idle at random. A scoreboard decodes every accepted byte itself
// and checks each result beat, field by field, in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgad_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandomBytes = 360;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;

  // Decoder phases as the scoreboard tracks them.
  typedef enum logic [1:0] {
    PhHeader,
    PhSkipId,
    PhPixels,
    PhDrain
  } decode_phase_e;

  // One result beat, in port order.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        done;
    logic [15:0] width;
    logic [15:0] height;
  } tga_result_t;

  // Byte-level decoder model and the queue of results it still expects.
  class tga_pixel_scoreboard;
    decode_phase_e phase;
    logic [4:0]    hdr_pos;
    logic [7:0]    id_len;
    logic [7:0]    cmap_kind;
    logic [7:0]    img_kind;
    logic [15:0]   width;
    logic [15:0]   height;
    logic [7:0]    depth;
    logic [7:0]    desc;
    logic [7:0]    skip_left;
    logic [31:0]   pix_left;
    logic [1:0]    byte_idx;
    logic [23:0]   held;
    tga_result_t   pending_results[$];
    int unsigned   errors;

    function new();
      phase     = PhHeader;
      hdr_pos   = '0;
      id_len    = '0;
      cmap_kind = '0;
      img_kind  = '0;
      width     = '0;
      height    = '0;
      depth     = '0;
      desc      = '0;
      skip_left = '0;
      pix_left  = '0;
      byte_idx  = '0;
      held      = '0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Close the current image: drain to end of file, or straight to a header.
    function void end_image(logic eof);
      phase    = eof ? PhHeader : PhDrain;
      hdr_pos  = '0;
      byte_idx = '0;
      held     = '0;
    endfunction

    function void push_error(logic [1:0] status);
      tga_result_t r;
      r        = '0;
      r.status = status;
      r.done   = 1'b1;
      pending_results.push_back(r);
    endfunction

    // Advance the model by one accepted input beat.
    function void note_byte(logic [7:0] b, logic eof);
      logic [1:0]  last_idx;
      logic        bad;
      tga_result_t r;
      case (phase)
        PhHeader: begin
          case (hdr_pos)
            5'd0:  id_len       = b;
            5'd1:  cmap_kind    = b;
            5'd2:  img_kind     = b;
            5'd12: width[7:0]   = b;
            5'd13: width[15:8]  = b;
            5'd14: height[7:0]  = b;
            5'd15: height[15:8] = b;
            5'd16: depth        = b;
            5'd17: desc         = b;
            default: ;
          endcase
          if (hdr_pos != HdrLastPos) begin
            hdr_pos = hdr_pos + 5'd1;
            if (eof) begin
              end_image(1'b1);
              push_error(StatusShort);
            end
          end else begin
            hdr_pos = '0;
            bad = (img_kind != TypeTrueCol) || (cmap_kind != 8'd0) ||
                  !((depth == Depth24) || (depth == Depth32)) ||
                  (width == 16'd0) || (height == 16'd0) || ((desc & DescMask) != 8'd0);
            if (bad) begin
              end_image(eof);
              push_error(StatusBadHeader);
            end else if (eof) begin
              end_image(1'b1);
              push_error(StatusShort);
            end else begin
              pix_left  = {16'd0, width} * {16'd0, height};
              skip_left = id_len;
              byte_idx  = '0;
              held      = '0;
              phase     = (skip_left != 8'd0) ? PhSkipId : PhPixels;
            end
          end
        end
        PhSkipId: begin
          if (eof) begin
            end_image(1'b1);
            push_error(StatusShort);
          end else begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 8'd0) begin
              phase    = PhPixels;
              byte_idx = '0;
              held     = '0;
            end
          end
        end
        PhPixels: begin
          last_idx = (depth == Depth32) ? 2'd3 : 2'd2;
          if (byte_idx < last_idx) begin
            held[8*byte_idx +: 8] = b;
            byte_idx = byte_idx + 2'd1;
            if (eof) begin
              end_image(1'b1);
              push_error(StatusShort);
            end
          end else begin
            r       = '0;
            r.blue  = held[7:0];
            r.green = held[15:8];
            if (last_idx == 2'd3) begin
              r.red   = held[23:16];
              r.alpha = b;
            end else begin
              r.red   = b;
              r.alpha = OpaqueAlpha;
            end
            r.status = StatusPixel;
            byte_idx = '0;
            held     = '0;
            pix_left = pix_left - 32'd1;
            if (pix_left == 32'd0) begin
              // Last pixel of the image carries the size.
              end_image(eof);
              r.done   = 1'b1;
              r.width  = width;
              r.height = height;
              pending_results.push_back(r);
            end else if (eof) begin
              // The error takes the place of this pixel.
              end_image(1'b1);
              push_error(StatusShort);
            end else begin
              pending_results.push_back(r);
            end
          end
        end
        default: begin
          if (eof) end_image(1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result beat against the oldest expectation.
    function void check_result(tga_result_t got);
      tga_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("done_res", want.done, got.done);
      compare_field("image_width", want.width, got.width);
      compare_field("image_height", want.height, got.height);
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = 8'd0;
  logic        end_of_file_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        done_res_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;

  tga_pixel_scoreboard pixel_board = new();

  logic [7:0]  file_bytes[$];
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 78;
  int unsigned bytes_sent    = 0;
  int unsigned stall_cycles  = 0;

  tga_truecolor_stream_decoder_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .done_res_o     (done_res_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  initial begin : result_sink
    tga_result_t got;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {status_o, red_o, green_o, blue_o, alpha_o, done_res_o,
               image_width_o, image_height_o};
        pixel_board.check_result(got);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one byte and wait until the decoder takes it.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= value;
    end_of_file_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixel_board.note_byte(value, is_last);
    bytes_sent++;
  endtask

  // Send the assembled file, flagging end of file on its final byte.
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    file_bytes.delete();
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) file_bytes.push_back(8'($urandom));
  endtask

  // Append an 18-byte header; colour map spec and origin are random.
  task automatic add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] kind, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth,
                            input logic [7:0] desc);
    file_bytes.push_back(id_len);
    file_bytes.push_back(cmap);
    file_bytes.push_back(kind);
    add_random(9);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(desc);
  endtask

  // One random file: mostly small valid images, then bad headers and noise.
  task automatic random_file();
    int unsigned pick;
    int unsigned ending;
    int unsigned cut;
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  kind;
    logic [7:0]  depth;
    logic [7:0]  desc;
    logic [15:0] w;
    logic [15:0] h;
    pick   = $urandom_range(99);
    id_len = ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom_range(1, 4));
    cmap   = 8'd0;
    kind   = TypeTrueCol;
    depth  = $urandom_range(1) ? Depth32 : Depth24;
    desc   = 8'($urandom_range(0, 63));
    w      = 16'($urandom_range(1, 3));
    h      = 16'($urandom_range(1, 3));
    if (pick < 60) begin
      add_header(id_len, cmap, kind, w, h, depth, desc);
      add_random(int'(id_len) + int'(w) * int'(h) * int'(depth) / 8);
      ending = $urandom_range(99);
      if (ending >= 80) begin
        // Truncated file: end of file lands anywhere before the proper end.
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else if (ending >= 65) begin
        add_random($urandom_range(1, 4));
      end
    end else if (pick < 80) begin
      id_len = 8'($urandom);
      w      = 16'($urandom);
      h      = 16'($urandom);
      case ($urandom_range(5))
        0: begin
          kind = 8'($urandom);
          if (kind == TypeTrueCol) kind = ~kind;
        end
        1: cmap = 8'($urandom_range(1, 255));
        2: begin
          depth = 8'($urandom);
          if ((depth == Depth24) || (depth == Depth32)) depth = ~depth;
        end
        3: w = 16'd0;
        4: h = 16'd0;
        default: desc = desc | 8'($urandom_range(1, 3) << 6);
      endcase
      add_header(id_len, cmap, kind, w, h, depth, desc);
      add_random($urandom_range(0, 4));
    end else if (pick < 90) begin
      add_random($urandom_range(1, 17));
    end else begin
      add_random($urandom_range(1, 30));
    end
    send_file();
  endtask

  // Directed files for the corner cases of the header and pixel stages.
  task automatic directed_files();
    // Header cut short by end of file.
    add_random(5);
    send_file();
    // Smallest 24-bit image, ending exactly on its only pixel.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd1, 16'd1, Depth24, 8'h00);
    add_random(3);
    send_file();
    // 32-bit image behind an ID field, with extreme component values.
    add_header(8'd2, 8'd0, TypeTrueCol, 16'd2, 16'd1, Depth32, 8'h3F);
    add_random(2);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    send_file();
    // Bad image type; the trailing bytes are drained up to end of file.
    add_header(8'd0, 8'd0, 8'd3, 16'd1, 16'd1, Depth24, 8'h00);
    add_random(3);
    send_file();
    // Bad depth, with end of file on the last header byte.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd1, 16'd1, 8'd16, 8'h00);
    send_file();
    // Zero width, colour map present, zero height, descriptor top bits set.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd0, 16'd1, Depth24, 8'h00);
    send_file();
    add_header(8'd0, 8'd1, TypeTrueCol, 16'd1, 16'd1, Depth24, 8'h00);
    send_file();
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd1, 16'd0, Depth32, 8'h00);
    send_file();
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd1, 16'd1, Depth24, 8'hC0);
    send_file();
    // Valid header, but the file ends on its last byte.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd4, 16'd4, Depth24, 8'h00);
    send_file();
    // File ends inside a long ID field.
    add_header(8'hFF, 8'd0, TypeTrueCol, 16'd1, 16'd1, Depth24, 8'h00);
    add_random(10);
    send_file();
    // Largest image; end of file on a completed pixel that is not the last.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'hFFFF, 16'hFFFF, Depth32, 8'h3F);
    add_random(8);
    send_file();
    // Image finished before end of file; the remainder is drained.
    add_header(8'd1, 8'd0, TypeTrueCol, 16'd1, 16'd2, Depth24, 8'h20);
    add_random(1 + 6 + 3);
    send_file();
    // File ends part-way through a pixel.
    add_header(8'd0, 8'd0, TypeTrueCol, 16'd2, 16'd2, Depth24, 8'h00);
    add_random(5);
    send_file();
  endtask

  // Reset, directed files, then random files under three idling regimes.
  initial begin : stimulus
    int unsigned random_start;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_files();
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      if (bytes_sent - random_start >= 2 * RandomBytes / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent - random_start >= RandomBytes / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 25;
      end
      random_file();
    end
    in_valid_i <= 1'b0;
    while (pixel_board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pixel_board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_front.sv
hw/rtl/tgad_queue.sv
hw/rtl/tgad_back.sv
hw/rtl/tga_truecolor_stream_decoder_unit.sv
tb/tb.sv
